### design/bbq_pkg.sv
// Package for the billboard quad vertex expander: field widths, word layouts,
// register indexes and offset divider sizing. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bbq_pkg;

  // Fraction bits of the corner offsets
  localparam int FRAC_BITS = 16;
  // Fraction bits of tick_delta
  localparam int TD_BITS   = 16;

  // Field widths
  localparam int POS_W     = 32;
  localparam int UV_W      = 17;
  localparam int COLOR_W   = 32;
  localparam int ROT_BITS  = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int OFF_W     = 32;

  localparam logic [UV_W-1:0]     TD_ONE      = UV_W'(1 << TD_BITS);
  localparam logic [ROT_BITS-1:0] ROT_W_RESET = ROT_BITS'(1 << (ROT_BITS - 2));

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_DELTA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_W      = 3'd7;

  // Input word layout (bit positions of each field)
  localparam int IN_CUR_LSB  = 0;
  localparam int IN_PREV_LSB = 3 * POS_W;
  localparam int IN_UMIN_LSB = 6 * POS_W;
  localparam int IN_UMAX_LSB = IN_UMIN_LSB + UV_W;
  localparam int IN_VMIN_LSB = IN_UMAX_LSB + UV_W;
  localparam int IN_VMAX_LSB = IN_VMIN_LSB + UV_W;
  localparam int IN_RGBA_LSB = IN_VMAX_LSB + UV_W;
  localparam int IN_FIELD_W  = IN_RGBA_LSB + COLOR_W;
  localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int IN_USER_W   = 1;

  // Output word layout
  localparam int OUT_FIELD_W = 3 * POS_W + 2 * UV_W + COLOR_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_USER_W  = 2;

  localparam logic [OUT_USER_W-1:0] CORNER_LAST = 2'd3;

  // Quaternion product codes, one per multiplier pass
  localparam int NPROD   = 10;
  localparam int PIDX_W  = $clog2(NPROD);
  localparam logic [PIDX_W-1:0] P_XX = 4'd0;
  localparam logic [PIDX_W-1:0] P_YY = 4'd1;
  localparam logic [PIDX_W-1:0] P_ZZ = 4'd2;
  localparam logic [PIDX_W-1:0] P_WW = 4'd3;
  localparam logic [PIDX_W-1:0] P_XY = 4'd4;
  localparam logic [PIDX_W-1:0] P_ZW = 4'd5;
  localparam logic [PIDX_W-1:0] P_XZ = 4'd6;
  localparam logic [PIDX_W-1:0] P_YW = 4'd7;
  localparam logic [PIDX_W-1:0] P_YZ = 4'd8;
  localparam logic [PIDX_W-1:0] P_XW = 4'd9;

  // Offset computation widths
  localparam int NOFF    = 6;
  localparam int OIDX_W  = $clog2(NOFF);
  localparam int PROD_W  = 2 * ROT_BITS;
  localparam int TERM_W  = PROD_W + 3;
  localparam int MAG_W   = TERM_W + 1;
  localparam int NSQ_W   = PROD_W + 1;
  localparam int DEN_W   = NSQ_W + 4;
  localparam int D_W     = DEN_W + 1;
  localparam int REM_W   = D_W + 1;
  localparam int N_W     = MAG_W + FRAC_BITS + 2;
  localparam int QUO_W   = FRAC_BITS;
  localparam int QCNT_W  = $clog2(QUO_W);

  // Position datapath widths
  localparam int DIFF_W  = POS_W + 1;
  localparam int IPROD_W = DIFF_W + UV_W + 1;
  localparam int CEN_W   = POS_W + 6;
  localparam int VSUM_W  = CEN_W + 1;

endpackage

`default_nettype wire

### design/billboard_quad_vertex_expander_unit.sv
// Billboard quad vertex expander: one particle word in, four vertex words out.
// Depends on bbq_pkg for widths, word layouts and register indexes.
//
// Usage:
//   s_axis carries one particle per word; s_axis_tuser is prev_valid.
//   m_axis carries one vertex per word; tuser is the corner index and tlast
//   marks the fourth vertex of a particle.
//   cfg_we_i/cfg_idx_i/cfg_data_i write tick_delta, the camera position and
//   the rotation quaternion. Every write restarts the corner offset sequence:
//   one shared 16x16 multiplier forms the products one by one, a sum step
//   follows, then per offset a bit-serial divider forms the quotient.
//   s_axis_tready stays low until the sequence is done.
// Pipeline:
//   Three register stages (input, interpolation product, centre) feed the
//   output register. The centre stage hands out one vertex per cycle while
//   the output register is free; the input and product stages can take the
//   next particle while the centre stage still hands out the last one.
// Reset clears all valid flags, loads the register reset values and zero
// offsets. When the receiver stalls, the output word holds and the stages
// behind it fill and then drop s_axis_tready.
`timescale 1ns / 1ps
`default_nettype none

module billboard_quad_vertex_expander_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [bbq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bbq_pkg::CFG_W-1:0]       cfg_data_i,
  // particle stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // cur_x, cur_y, cur_z, prev_x, prev_y, prev_z, u_min, u_max, v_min, v_max,
  // rgba, zero pad
  input  wire logic [bbq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // prev_valid
  input  wire logic [bbq_pkg::IN_USER_W-1:0]   s_axis_tuser,
  // vertex stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, vert_color, zero pad
  output logic [bbq_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // corner
  output logic [bbq_pkg::OUT_USER_W-1:0]       m_axis_tuser,
  output logic                                 m_axis_tlast
);
  import bbq_pkg::*;

  // Offset sequencer codes
  localparam logic [2:0] SEQ_IDLE  = 3'd0;
  localparam logic [2:0] SEQ_MUL   = 3'd1;
  localparam logic [2:0] SEQ_SUM   = 3'd2;
  localparam logic [2:0] SEQ_PREP  = 3'd3;
  localparam logic [2:0] SEQ_LOAD  = 3'd4;
  localparam logic [2:0] SEQ_DIV   = 3'd5;
  localparam logic [2:0] SEQ_STORE = 3'd6;

  localparam logic signed [IPROD_W:0] HALF_TD = (IPROD_W + 1)'(1 << (TD_BITS - 1));
  localparam logic signed [VSUM_W-1:0] VMAX =
    $signed({{(VSUM_W - POS_W + 1){1'b0}}, {(POS_W - 1){1'b1}}});
  localparam logic signed [VSUM_W-1:0] VMIN =
    $signed({{(VSUM_W - POS_W + 1){1'b1}}, {(POS_W - 1){1'b0}}});

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [UV_W-1:0]            td_q;
  logic signed [POS_W-1:0]    cam_q [3];
  logic signed [ROT_BITS-1:0] rot_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      td_q     <= '0;
      cam_q[0] <= '0;
      cam_q[1] <= '0;
      cam_q[2] <= '0;
      rot_q[0] <= '0;
      rot_q[1] <= '0;
      rot_q[2] <= '0;
      rot_q[3] <= ROT_W_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TICK_DELTA: td_q     <= cfg_data_i[UV_W-1:0];
        REG_CAMERA_X:   cam_q[0] <= cfg_data_i[POS_W-1:0];
        REG_CAMERA_Y:   cam_q[1] <= cfg_data_i[POS_W-1:0];
        REG_CAMERA_Z:   cam_q[2] <= cfg_data_i[POS_W-1:0];
        REG_ROT_X:      rot_q[0] <= cfg_data_i[ROT_BITS-1:0];
        REG_ROT_Y:      rot_q[1] <= cfg_data_i[ROT_BITS-1:0];
        REG_ROT_Z:      rot_q[2] <= cfg_data_i[ROT_BITS-1:0];
        REG_ROT_W:      rot_q[3] <= cfg_data_i[ROT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Corner offset sequencer: shared multiplier, sums, bit-serial divider
  // ---------------------------------------------------------------------
  logic [2:0]                 seq_state_q;
  logic [PIDX_W-1:0]          pidx_q;
  logic [OIDX_W-1:0]          oidx_q;
  logic [QCNT_W-1:0]          dcnt_q;
  logic signed [OFF_W-1:0]    offs_q [NOFF];

  logic signed [PROD_W-1:0]   prod_q [NPROD];
  logic signed [TERM_W-1:0]   term_q [6];
  logic [NSQ_W-1:0]           nsq_q;
  logic [DEN_W-1:0]           den_q;
  logic [MAG_W-1:0]           mag_q;
  logic                       neg_q;
  logic [REM_W-1:0]           rem_q;
  logic [QUO_W-1:0]           lo_q;
  logic [QUO_W-1:0]           quo_q;

  logic signed [ROT_BITS-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [TERM_W-1:0]   xx, yy, zz, ww, xy, zw, xz, yw, yz, xw;
  logic signed [TERM_W-1:0]   term_d [6];
  logic signed [TERM_W-1:0]   nsq_sum;
  logic [OIDX_W-1:0]          axis_sel;
  logic signed [MAG_W-1:0]    pair_v;
  logic                       pair_sum;
  logic [N_W-1:0]             div_num;
  logic [D_W-1:0]             div_den;
  logic [REM_W-1:0]           rem_sh;
  logic                       rem_ge;
  logic [OFF_W-1:0]           quo_ext;

  // Pick the multiplier operands for this pass
  always_comb begin
    case (pidx_q)
      P_XX:    begin mul_a = rot_q[0]; mul_b = rot_q[0]; end
      P_YY:    begin mul_a = rot_q[1]; mul_b = rot_q[1]; end
      P_ZZ:    begin mul_a = rot_q[2]; mul_b = rot_q[2]; end
      P_WW:    begin mul_a = rot_q[3]; mul_b = rot_q[3]; end
      P_XY:    begin mul_a = rot_q[0]; mul_b = rot_q[1]; end
      P_ZW:    begin mul_a = rot_q[2]; mul_b = rot_q[3]; end
      P_XZ:    begin mul_a = rot_q[0]; mul_b = rot_q[2]; end
      P_YW:    begin mul_a = rot_q[1]; mul_b = rot_q[3]; end
      P_YZ:    begin mul_a = rot_q[1]; mul_b = rot_q[2]; end
      P_XW:    begin mul_a = rot_q[0]; mul_b = rot_q[3]; end
      default: begin mul_a = '0;       mul_b = '0;       end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Form the norm and the rotated-axis terms from the stored products
  always_comb begin
    xx = TERM_W'(prod_q[P_XX]);
    yy = TERM_W'(prod_q[P_YY]);
    zz = TERM_W'(prod_q[P_ZZ]);
    ww = TERM_W'(prod_q[P_WW]);
    xy = TERM_W'(prod_q[P_XY]);
    zw = TERM_W'(prod_q[P_ZW]);
    xz = TERM_W'(prod_q[P_XZ]);
    yw = TERM_W'(prod_q[P_YW]);
    yz = TERM_W'(prod_q[P_YZ]);
    xw = TERM_W'(prod_q[P_XW]);
    nsq_sum   = xx + yy + zz + ww;
    term_d[0] = xx - yy - zz + ww;
    term_d[1] = (xy + zw) <<< 1;
    term_d[2] = (xz - yw) <<< 1;
    term_d[3] = (xy - zw) <<< 1;
    term_d[4] = yy - xx - zz + ww;
    term_d[5] = (yz + xw) <<< 1;
  end

  // The first three offsets negate the axis sum, the last three take the difference
  always_comb begin
    pair_sum = (oidx_q < OIDX_W'(3));
    axis_sel = pair_sum ? oidx_q : oidx_q - OIDX_W'(3);
    if (pair_sum) begin
      pair_v = MAG_W'(term_q[axis_sel]) + MAG_W'(term_q[axis_sel + OIDX_W'(3)]);
    end else begin
      pair_v = MAG_W'(term_q[axis_sel + OIDX_W'(3)]) - MAG_W'(term_q[axis_sel]);
    end
  end

  // Divider: (|num| * 2^(F+1) + 10n) / (20n), one quotient bit per cycle
  always_comb begin
    div_num = (N_W'(mag_q) << (FRAC_BITS + 1)) + N_W'(den_q);
    div_den = {den_q, 1'b0};
    rem_sh  = {rem_q[REM_W-2:0], lo_q[QUO_W-1]};
    rem_ge  = (rem_sh >= REM_W'(div_den));
    quo_ext = OFF_W'(quo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_state_q <= SEQ_IDLE;
      pidx_q      <= '0;
      oidx_q      <= '0;
      dcnt_q      <= '0;
      for (int i = 0; i < NOFF; i++) begin
        offs_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      // restart on every write
      seq_state_q <= SEQ_MUL;
      pidx_q      <= '0;
    end else begin
      case (seq_state_q)
        SEQ_MUL: begin
          if (pidx_q == PIDX_W'(NPROD - 1)) begin
            seq_state_q <= SEQ_SUM;
          end else begin
            pidx_q <= pidx_q + PIDX_W'(1);
          end
        end
        SEQ_SUM: begin
          oidx_q      <= '0;
          seq_state_q <= SEQ_PREP;
        end
        SEQ_PREP: begin
          if (nsq_q == '0) begin
            for (int i = 0; i < NOFF; i++) begin
              offs_q[i] <= '0;
            end
            seq_state_q <= SEQ_IDLE;
          end else begin
            seq_state_q <= SEQ_LOAD;
          end
        end
        SEQ_LOAD: begin
          dcnt_q      <= QCNT_W'(QUO_W - 1);
          seq_state_q <= SEQ_DIV;
        end
        SEQ_DIV: begin
          if (dcnt_q == '0) begin
            seq_state_q <= SEQ_STORE;
          end else begin
            dcnt_q <= dcnt_q - QCNT_W'(1);
          end
        end
        SEQ_STORE: begin
          offs_q[oidx_q] <= neg_q ? -$signed(quo_ext) : $signed(quo_ext);
          if (oidx_q == OIDX_W'(NOFF - 1)) begin
            seq_state_q <= SEQ_IDLE;
          end else begin
            oidx_q      <= oidx_q + OIDX_W'(1);
            seq_state_q <= SEQ_PREP;
          end
        end
        default: seq_state_q <= SEQ_IDLE;
      endcase
    end
  end

  // Sequencer datapath registers
  always_ff @(posedge clk_i) begin
    case (seq_state_q)
      SEQ_MUL: prod_q[pidx_q] <= mul_p;
      SEQ_SUM: begin
        nsq_q <= nsq_sum[NSQ_W-1:0];
        for (int i = 0; i < 6; i++) begin
          term_q[i] <= term_d[i];
        end
      end
      SEQ_PREP: begin
        den_q <= (DEN_W'(nsq_q) << 3) + (DEN_W'(nsq_q) << 1);
        mag_q <= pair_v[MAG_W-1] ? MAG_W'(-pair_v) : MAG_W'(pair_v);
        neg_q <= pair_sum ? (pair_v > 0) : pair_v[MAG_W-1];
      end
      SEQ_LOAD: begin
        rem_q <= REM_W'(div_num >> QUO_W);
        lo_q  <= div_num[QUO_W-1:0];
        quo_q <= '0;
      end
      SEQ_DIV: begin
        rem_q <= rem_ge ? rem_sh - REM_W'(div_den) : rem_sh;
        lo_q  <= {lo_q[QUO_W-2:0], 1'b0};
        quo_q <= {quo_q[QUO_W-2:0], rem_ge};
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Particle pipeline: input, interpolation product, centre, output
  // ---------------------------------------------------------------------
  logic                     a_valid_q, b_valid_q, c_valid_q, out_valid_q;
  logic [IN_DATA_W-1:0]     a_data_q;
  logic                     a_pv_q;

  logic signed [IPROD_W-1:0] b_prod_q [3];
  logic signed [POS_W-1:0]   b_cur_q  [3];
  logic signed [POS_W-1:0]   b_prev_q [3];
  logic                      b_pv_q;
  logic [UV_W-1:0]           b_umin_q, b_umax_q, b_vmin_q, b_vmax_q;
  logic [COLOR_W-1:0]        b_rgba_q;

  logic signed [CEN_W-1:0]   c_cen_q [3];
  logic [1:0]                c_cnt_q;
  logic [UV_W-1:0]           c_umin_q, c_umax_q, c_vmin_q, c_vmax_q;
  logic [COLOR_W-1:0]        c_rgba_q;

  logic [OUT_DATA_W-1:0]     out_data_q;
  logic [OUT_USER_W-1:0]     out_corner_q;
  logic                      out_last_q;

  logic out_free, c_emit, c_done, c_take, b_take, b_adv, a_take, a_adv, s_fire;
  logic seq_busy;

  // Stage handshakes: each stage frees when the one ahead takes its word
  always_comb begin
    seq_busy = (seq_state_q != SEQ_IDLE);
    out_free = !out_valid_q || m_axis_tready;
    c_emit   = c_valid_q && out_free;
    c_done   = c_emit && (c_cnt_q == CORNER_LAST);
    c_take   = !c_valid_q || c_done;
    b_take   = !b_valid_q || c_take;
    b_adv    = b_valid_q && c_take;
    a_take   = !a_valid_q || b_take;
    a_adv    = a_valid_q && b_take;
  end

  assign s_axis_tready = a_take && !seq_busy;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Stage A: interpolation product td * (cur - prev)
  logic [UV_W-1:0]           td_sat;
  logic signed [POS_W-1:0]   a_cur  [3];
  logic signed [POS_W-1:0]   a_prev [3];
  logic signed [DIFF_W-1:0]  a_diff [3];
  logic signed [IPROD_W-1:0] a_prod [3];

  always_comb begin
    td_sat = (td_q > TD_ONE) ? TD_ONE : td_q;
    for (int j = 0; j < 3; j++) begin
      a_cur[j]  = a_data_q[IN_CUR_LSB + j * POS_W +: POS_W];
      a_prev[j] = a_data_q[IN_PREV_LSB + j * POS_W +: POS_W];
      a_diff[j] = DIFF_W'(a_cur[j]) - DIFF_W'(a_prev[j]);
      a_prod[j] = $signed({1'b0, td_sat}) * a_diff[j];
    end
  end

  // Stage B: round, add to prev (or take cur without prev_valid), subtract camera
  logic signed [IPROD_W:0]   b_rnd [3];
  logic signed [CEN_W-1:0]   b_step [3];
  logic signed [CEN_W-1:0]   b_cen [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      b_rnd[j]  = (IPROD_W + 1)'(b_prod_q[j]) + HALF_TD;
      b_step[j] = CEN_W'(b_rnd[j] >>> TD_BITS);
      if (b_pv_q) begin
        b_cen[j] = CEN_W'(b_prev_q[j]) + b_step[j] - CEN_W'(cam_q[j]);
      end else begin
        b_cen[j] = CEN_W'(b_cur_q[j]) - CEN_W'(cam_q[j]);
      end
    end
  end

  // Stage C: add or subtract the corner offset and saturate
  logic signed [VSUM_W-1:0]  c_off [3];
  logic signed [VSUM_W-1:0]  c_sum [3];
  logic [POS_W-1:0]          c_pos [3];
  logic [UV_W-1:0]           c_u, c_v;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      c_off[j] = c_cnt_q[0] ? VSUM_W'(offs_q[3 + j]) : VSUM_W'(offs_q[j]);
      c_sum[j] = VSUM_W'(c_cen_q[j]) + (c_cnt_q[1] ? -c_off[j] : c_off[j]);
      if (c_sum[j] > VMAX) begin
        c_pos[j] = VMAX[POS_W-1:0];
      end else if (c_sum[j] < VMIN) begin
        c_pos[j] = VMIN[POS_W-1:0];
      end else begin
        c_pos[j] = c_sum[j][POS_W-1:0];
      end
    end
    c_u = c_cnt_q[1] ? c_umin_q : c_umax_q;
    c_v = (c_cnt_q[0] ^ c_cnt_q[1]) ? c_vmin_q : c_vmax_q;
  end

  // Valid flags and corner count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      c_cnt_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_take) begin
        a_valid_q <= s_fire;
      end
      if (b_take) begin
        b_valid_q <= a_valid_q;
      end
      if (c_take) begin
        c_valid_q <= b_valid_q;
        c_cnt_q   <= '0;
      end else if (c_emit) begin
        c_cnt_q <= c_cnt_q + 2'd1;
      end
      if (out_free) begin
        out_valid_q <= c_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_data_q <= s_axis_tdata;
      a_pv_q   <= s_axis_tuser[0];
    end
    if (a_adv) begin
      for (int j = 0; j < 3; j++) begin
        b_prod_q[j] <= a_prod[j];
        b_cur_q[j]  <= a_cur[j];
        b_prev_q[j] <= a_prev[j];
      end
      b_pv_q   <= a_pv_q;
      b_umin_q <= a_data_q[IN_UMIN_LSB +: UV_W];
      b_umax_q <= a_data_q[IN_UMAX_LSB +: UV_W];
      b_vmin_q <= a_data_q[IN_VMIN_LSB +: UV_W];
      b_vmax_q <= a_data_q[IN_VMAX_LSB +: UV_W];
      b_rgba_q <= a_data_q[IN_RGBA_LSB +: COLOR_W];
    end
    if (b_adv) begin
      for (int j = 0; j < 3; j++) begin
        c_cen_q[j] <= b_cen[j];
      end
      c_umin_q <= b_umin_q;
      c_umax_q <= b_umax_q;
      c_vmin_q <= b_vmin_q;
      c_vmax_q <= b_vmax_q;
      c_rgba_q <= b_rgba_q;
    end
    if (c_emit) begin
      out_data_q   <= OUT_DATA_W'({c_rgba_q, c_v, c_u, c_pos[2], c_pos[1], c_pos[0]});
      out_corner_q <= c_cnt_q;
      out_last_q   <= (c_cnt_q == CORNER_LAST);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_corner_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_busy |-> !s_axis_tready)
    else $error("particle taken while offsets are being computed");

  a_write_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (seq_state_q == SEQ_MUL))
    else $error("register write did not restart the offset sequence");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_state_q == SEQ_DIV) |-> (rem_q < REM_W'({den_q, 1'b0})))
    else $error("divider remainder reached the divisor");

  a_last_on_corner3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == CORNER_LAST))
    else $error("last flag on a corner other than the fourth");

  a_corner_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid_q && (c_cnt_q != 2'd0) && m_axis_tvalid)
      |-> (m_axis_tuser == c_cnt_q - 2'd1))
    else $error("vertex corners out of order");

endmodule

`default_nettype wire
